[sv/nrfr_pkg.sv]
// ----------------------------------------------------------------------------
// nrfr_pkg
// shared types and constants for the newline to fixed record formatter
// ----------------------------------------------------------------------------
package nrfr_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] PAD_BYTE     = 8'd32;

    localparam int REC_LEN_W   = 16;
    localparam int BLK_W       = 20;
    localparam int TRUNC_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int TDATA_W     = 64;

    localparam logic [REC_LEN_W-1:0] RECORD_LENGTH_RESET = 16'd80;
    localparam logic [BLK_W-1:0]     BLOCK_SIZE_RESET    = 20'd32768;
    localparam logic [BLK_W-1:0]     BLOCK_BYTES_MAX     = '1;
    localparam logic [TRUNC_W-1:0]   TRUNC_MAX           = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RECORD_LENGTH = 2'd0,
        CFG_BLOCK_SIZE    = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [TRUNC_W-1:0]   truncated_count;
        logic [BLK_W-1:0]     block_bytes;
        logic                 block_done;
        logic                 record_done;
        logic [REC_LEN_W-1:0] run_length;
        logic [7:0]           out_byte;
    } result_t;

endpackage

[sv/newline_records_to_fixed_records.sv]
// ----------------------------------------------------------------------------
// newline_records_to_fixed_records
// turns newline-terminated text into fixed-length blank-padded records
// ----------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata, tlast = record_done
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// one word per cycle in while s_axis_tready is high; each result is registered in the output or skid register
// the record and block counters update in a single pass at acceptance
// a skid register holds one result while the output stalls, so input is still taken until it fills
// rst_n clears the counters and valid flags and loads record_length 80, block_size 32768
// ----------------------------------------------------------------------------
module newline_records_to_fixed_records
    import nrfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] out_byte, [23:8] run_length, [24] block_done,
    // [44:25] block_bytes, [60:45] truncated_count, zero above
    output logic [TDATA_W-1:0]     m_axis_tdata,
    output logic                   m_axis_tlast,   // record_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BLK_W-1:0]       cfg_data
);

    logic [REC_LEN_W-1:0] record_length_reg;
    logic [BLK_W-1:0]     block_size_reg;

    logic [REC_LEN_W-1:0] fill_reg, fill_next;
    logic                 discard_reg, discard_next;
    logic [BLK_W-1:0]     total_reg, total_next;
    logic [TRUNC_W-1:0]   trunc_reg, trunc_next;

    result_t              res;
    logic                 res_valid;
    logic                 accept;
    logic                 push;

    result_t              out_reg;
    logic                 out_valid_reg;
    result_t              skid_reg;
    logic                 skid_valid_reg;
    logic                 out_load;

    logic                 is_nl;
    logic [BLK_W:0]       sum;
    logic                 blk_done;
    logic [BLK_W-1:0]     shown;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_length_reg <= RECORD_LENGTH_RESET;
            block_size_reg    <= BLOCK_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_RECORD_LENGTH)
                record_length_reg <= cfg_data[REC_LEN_W-1:0];
            else if (cfg_index == CFG_BLOCK_SIZE)
                block_size_reg <= cfg_data;
        end
    end

    // record and block bookkeeping for one word
    always_comb
    begin
        is_nl    = (s_axis_tdata == NEWLINE_BYTE);
        sum      = {1'b0, total_reg} + {{(BLK_W+1-REC_LEN_W){1'b0}}, record_length_reg};
        blk_done = (sum >= {1'b0, block_size_reg});
        shown    = sum[BLK_W] ? BLOCK_BYTES_MAX : sum[BLK_W-1:0];

        fill_next    = fill_reg;
        discard_next = discard_reg;
        total_next   = total_reg;
        trunc_next   = trunc_reg;
        res_valid    = 1'b0;

        res.out_byte        = PAD_BYTE;
        res.run_length      = '0;
        res.record_done     = 1'b1;
        res.block_done      = blk_done;
        res.block_bytes     = shown;
        res.truncated_count = trunc_reg;

        if (discard_reg)
        begin
            if (is_nl)
            begin
                discard_next = 1'b0;
                if (trunc_reg != TRUNC_MAX)
                    trunc_next = trunc_reg + {{(TRUNC_W-1){1'b0}}, 1'b1};
            end
        end
        else if (is_nl || (fill_reg >= record_length_reg))
        begin
            // close the record, with a pad run on newline
            res_valid  = 1'b1;
            fill_next  = '0;
            total_next = blk_done ? '0 : sum[BLK_W-1:0];
            if (is_nl)
            begin
                if (fill_reg < record_length_reg)
                    res.run_length = record_length_reg - fill_reg;
            end
            else
            begin
                discard_next = 1'b1;
            end
        end
        else
        begin
            res_valid       = 1'b1;
            fill_next       = fill_reg + {{(REC_LEN_W-1){1'b0}}, 1'b1};
            res.out_byte    = s_axis_tdata;
            res.run_length  = {{(REC_LEN_W-1){1'b0}}, 1'b1};
            res.record_done = 1'b0;
            res.block_done  = 1'b0;
            res.block_bytes = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            discard_reg <= 1'b0;
            total_reg   <= '0;
            trunc_reg   <= '0;
        end
        else if (accept)
        begin
            fill_reg    <= fill_next;
            discard_reg <= discard_next;
            total_reg   <= total_next;
            trunc_reg   <= trunc_next;
        end
    end

    // output register with skid stage
    assign out_load = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.record_done;
    assign m_axis_tdata  = {3'b000, out_reg.truncated_count, out_reg.block_bytes,
                            out_reg.block_done, out_reg.run_length, out_reg.out_byte};

endmodule
